// File: rtl/jvs_pkg.sv
// ----------------------------------------------------------------------------
// jvs_pkg
// shared types, sizes and codes for the json value extent scanner
// ----------------------------------------------------------------------------
package jvs_pkg;

  // sizing
  localparam int MAX_DEPTH     = 64;
  localparam int LENGTH_WIDTH  = 24;
  localparam int DEPTH_LIMIT_W = 7;
  localparam int ADDR_W        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W         = $clog2(MAX_DEPTH + 1);
  localparam int LIM_CMP_W     = (CNT_W > DEPTH_LIMIT_W) ? CNT_W : DEPTH_LIMIT_W;

  localparam logic [DEPTH_LIMIT_W-1:0] DEPTH_LIMIT_RESET = DEPTH_LIMIT_W'(64);

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_FIRST = 3'd1;
  localparam logic [2:0] ST_MISMATCH  = 3'd2;
  localparam logic [2:0] ST_TOO_DEEP  = 3'd3;
  localparam logic [2:0] ST_RAN_OUT   = 3'd4;

  // value kinds
  localparam logic [2:0] KIND_OBJECT = 3'd0;
  localparam logic [2:0] KIND_ARRAY  = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_BOOL   = 3'd3;
  localparam logic [2:0] KIND_NULL   = 3'd4;
  localparam logic [2:0] KIND_NUMBER = 3'd5;

  // input beat
  typedef struct packed {
    logic [7:0] text_byte;
    logic       start_req;
    logic       last;
  } jvs_in_t;

  // result beat
  typedef struct packed {
    logic [2:0]              status;
    logic [2:0]              value_kind;
    logic [LENGTH_WIDTH-1:0] length;
  } jvs_out_t;

  // closer stack command, depth is the nesting depth before the operation
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             bit_val;
    logic [CNT_W-1:0] depth;
  } stack_cmd_t;

endpackage

// File: rtl/json_value_extent_scanner.sv
// ----------------------------------------------------------------------------
// json_value_extent_scanner
// finds the extent of the json value that starts at a marked byte
// ----------------------------------------------------------------------------
//
//  channel   handshake                payload               direction
//  -------   ----------------------   -------------------   ---------
//  cfg       cfg_valid / cfg_ready    cfg_data (limit)      in
//  byte      byte_valid / byte_stall  byte_item (jvs_in_t)  in
//  result    result_valid/result_stall result (jvs_out_t)   out
//
//  one byte per cycle while the receiver does not stall; a beat goes through the
//  byte register and the scan logic into the result register
//  the per-byte step (stack top compare, push or pop, counter) sets the rate;
//  the closer stack caches its top two entries in flops
//  reset (rst, synchronous) clears the scan state and sets the limit to 64;
//  stack memory is not cleared, only entries pushed in the current scan are read
//  result_stall holds a valid result register; a full byte register then holds
//  too and byte_stall rises in the same cycle, with no beat dropped
//  cfg_ready is always high; the limit may only change while the block is idle
//
module json_value_extent_scanner (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [jvs_pkg::DEPTH_LIMIT_W-1:0]  cfg_data,
  // byte stream
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  jvs_pkg::jvs_in_t                   byte_item,
  // results
  output logic                               result_valid,
  input  logic                               result_stall,
  output jvs_pkg::jvs_out_t                  result
);

  logic [jvs_pkg::DEPTH_LIMIT_W-1:0] depth_limit;

  // byte register
  logic             hold_valid;
  jvs_pkg::jvs_in_t hold;

  // scan step
  logic                step;
  logic                take;
  logic                fire;
  logic                tos;
  jvs_pkg::jvs_out_t   res;
  jvs_pkg::stack_cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= jvs_pkg::DEPTH_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      depth_limit <= cfg_data;
    end
  end

  // the held byte moves on whenever the result slot is free or draining
  assign step       = hold_valid && (!result_valid || !result_stall);
  assign byte_stall = hold_valid && !step;
  assign take       = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (step) begin
      hold_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      hold <= byte_item;
    end
  end

  jvs_scan_ctl u_ctl (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (hold),
    .depth_limit (depth_limit),
    .tos         (tos),
    .cmd         (cmd),
    .fire        (fire),
    .res         (res)
  );

  jvs_closer_stack u_stack (
    .clk (clk),
    .cmd (cmd),
    .tos (tos)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= fire;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && fire) begin
      result <= res;
    end
  end

endmodule

// File: rtl/jvs_closer_stack.sv
// ----------------------------------------------------------------------------
// jvs_closer_stack
// stack of closer kinds (0 brace, 1 bracket) with top and next-below cached
// in flops, deeper entries in a one-write one-read memory
// ----------------------------------------------------------------------------
module jvs_closer_stack (
  input  logic               clk,
  input  jvs_pkg::stack_cmd_t cmd,
  output logic               tos
);

  logic                      mem [jvs_pkg::MAX_DEPTH];
  logic                      below;
  logic [jvs_pkg::ADDR_W-1:0] wr_addr;
  logic [jvs_pkg::ADDR_W-1:0] rd_addr;

  // push writes the new entry at the old depth
  assign wr_addr = jvs_pkg::ADDR_W'(cmd.depth);
  // after a pop the entry below the new top sits at old depth minus three
  assign rd_addr = jvs_pkg::ADDR_W'(cmd.depth - jvs_pkg::CNT_W'(3));

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= cmd.bit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      tos   <= cmd.bit_val;
      below <= tos;
    end else if (cmd.pop) begin
      tos   <= below;
      below <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/jvs_scan_ctl.sv
// ----------------------------------------------------------------------------
// jvs_scan_ctl
// scan state and per-byte next-state logic, one byte per step
// ----------------------------------------------------------------------------
module jvs_scan_ctl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  jvs_pkg::jvs_in_t                    item,
  input  logic [jvs_pkg::DEPTH_LIMIT_W-1:0]   depth_limit,
  input  logic                                tos,
  output jvs_pkg::stack_cmd_t                 cmd,
  output logic                                fire,
  output jvs_pkg::jvs_out_t                   res
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_CONT = 3'd1;
  localparam logic [2:0] PH_CSTR = 3'd2;
  localparam logic [2:0] PH_STR  = 3'd3;
  localparam logic [2:0] PH_TOK  = 3'd4;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // state
  logic [2:0]                      phase, phase_next;
  logic [jvs_pkg::CNT_W-1:0]        nest_depth, nest_depth_next;
  logic                            escape_pending, escape_pending_next;
  logic [2:0]                      kind_held, kind_held_next;
  logic [jvs_pkg::LENGTH_WIDTH-1:0] byte_count, byte_count_next;

  logic [jvs_pkg::LENGTH_WIDTH-1:0] count_inc;
  logic [jvs_pkg::LIM_CMP_W-1:0]    lim_cfg, lim_max, eff_limit, depth_cmp;
  logic [7:0]                      b;
  logic                            is_delim;
  logic                            push, pop, push_bit;
  logic [jvs_pkg::CNT_W-1:0]        push_depth;
  logic                            halt;
  logic                            known;
  logic [2:0]                      kind_new;
  logic [2:0]                      st;
  logic [jvs_pkg::LENGTH_WIDTH-1:0] len;

  assign b         = item.text_byte;
  assign count_inc = (&byte_count) ? byte_count
                                   : byte_count + jvs_pkg::LENGTH_WIDTH'(1);
  assign lim_cfg   = jvs_pkg::LIM_CMP_W'(depth_limit);
  assign lim_max   = jvs_pkg::LIM_CMP_W'(jvs_pkg::MAX_DEPTH);
  assign eff_limit = (lim_cfg < lim_max) ? lim_cfg : lim_max;
  assign depth_cmp = jvs_pkg::LIM_CMP_W'(nest_depth);
  assign is_delim  = b inside {CH_COMMA, CH_RBRACE, CH_RBRACK, CH_SPACE, CH_TAB, CH_LF, CH_CR};

  // first-byte decode
  always_comb begin
    known    = 1'b1;
    kind_new = jvs_pkg::KIND_OBJECT;
    if (b == CH_LBRACE) begin
      kind_new = jvs_pkg::KIND_OBJECT;
    end else if (b == CH_LBRACK) begin
      kind_new = jvs_pkg::KIND_ARRAY;
    end else if (b == CH_QUOTE) begin
      kind_new = jvs_pkg::KIND_STRING;
    end else if (b == CH_T || b == CH_F) begin
      kind_new = jvs_pkg::KIND_BOOL;
    end else if (b == CH_N) begin
      kind_new = jvs_pkg::KIND_NULL;
    end else if (b == CH_MINUS || b inside {[CH_ZERO:CH_NINE]}) begin
      kind_new = jvs_pkg::KIND_NUMBER;
    end else begin
      known = 1'b0;
    end
  end

  always_comb begin
    phase_next          = phase;
    nest_depth_next     = nest_depth;
    escape_pending_next = escape_pending;
    kind_held_next      = kind_held;
    byte_count_next     = byte_count;
    push                = 1'b0;
    pop                 = 1'b0;
    push_bit            = 1'b0;
    push_depth          = nest_depth;
    halt                = 1'b0;
    fire                = 1'b0;
    st                  = jvs_pkg::ST_OK;
    len                 = byte_count;

    if (item.start_req) begin
      byte_count_next     = '0;
      nest_depth_next     = '0;
      escape_pending_next = 1'b0;
      if (!known) begin
        kind_held_next = jvs_pkg::KIND_OBJECT;
        fire           = 1'b1;
        halt           = 1'b1;
        st             = jvs_pkg::ST_BAD_FIRST;
        len            = '0;
        phase_next     = PH_IDLE;
      end else begin
        kind_held_next = kind_new;
        if (kind_new == jvs_pkg::KIND_OBJECT || kind_new == jvs_pkg::KIND_ARRAY) begin
          if (eff_limit == '0) begin
            fire       = 1'b1;
            halt       = 1'b1;
            st         = jvs_pkg::ST_TOO_DEEP;
            len        = '0;
            phase_next = PH_IDLE;
          end else begin
            push            = 1'b1;
            push_bit        = kind_new[0];
            push_depth      = '0;
            nest_depth_next = jvs_pkg::CNT_W'(1);
            phase_next      = PH_CONT;
          end
        end else begin
          phase_next = (kind_new == jvs_pkg::KIND_STRING) ? PH_STR : PH_TOK;
        end
        if (!halt) begin
          byte_count_next = jvs_pkg::LENGTH_WIDTH'(1);
        end
      end
    end else begin
      case (phase)
        PH_TOK: begin
          if (is_delim) begin
            fire       = 1'b1;
            halt       = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            byte_count_next = count_inc;
          end
        end
        PH_STR, PH_CSTR: begin
          byte_count_next = count_inc;
          if (b == CH_BSLASH) begin
            escape_pending_next = ~escape_pending;
          end else begin
            escape_pending_next = 1'b0;
            if (b == CH_QUOTE && !escape_pending) begin
              if (phase == PH_STR) begin
                fire       = 1'b1;
                halt       = 1'b1;
                len        = count_inc;
                phase_next = PH_IDLE;
              end else begin
                phase_next = PH_CONT;
              end
            end
          end
        end
        PH_CONT: begin
          if (b == CH_QUOTE) begin
            escape_pending_next = 1'b0;
            phase_next          = PH_CSTR;
            byte_count_next     = count_inc;
          end else if (b == CH_LBRACE || b == CH_LBRACK) begin
            if (depth_cmp >= eff_limit) begin
              fire       = 1'b1;
              halt       = 1'b1;
              st         = jvs_pkg::ST_TOO_DEEP;
              phase_next = PH_IDLE;
            end else begin
              push            = 1'b1;
              push_bit        = (b == CH_LBRACK);
              nest_depth_next = nest_depth + jvs_pkg::CNT_W'(1);
              byte_count_next = count_inc;
            end
          end else if (b == CH_RBRACE || b == CH_RBRACK) begin
            if (nest_depth == '0 || tos != (b == CH_RBRACK)) begin
              fire       = 1'b1;
              halt       = 1'b1;
              st         = jvs_pkg::ST_MISMATCH;
              phase_next = PH_IDLE;
            end else begin
              pop             = 1'b1;
              nest_depth_next = nest_depth - jvs_pkg::CNT_W'(1);
              byte_count_next = count_inc;
              if (nest_depth == jvs_pkg::CNT_W'(1)) begin
                fire       = 1'b1;
                halt       = 1'b1;
                len        = count_inc;
                phase_next = PH_IDLE;
              end
            end
          end else begin
            byte_count_next = count_inc;
          end
        end
        default: begin
          // idle: stray bytes are dropped
          halt = 1'b1;
        end
      endcase
    end

    // buffer end with the scan still open
    if (!halt && item.last) begin
      fire       = 1'b1;
      st         = (phase_next == PH_TOK) ? jvs_pkg::ST_OK : jvs_pkg::ST_RAN_OUT;
      len        = byte_count_next;
      phase_next = PH_IDLE;
    end
  end

  assign res.status     = st;
  assign res.value_kind = kind_held_next;
  assign res.length     = len;

  assign cmd.push    = step & push;
  assign cmd.pop     = step & pop;
  assign cmd.bit_val = push_bit;
  assign cmd.depth   = push_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      nest_depth     <= '0;
      escape_pending <= 1'b0;
      kind_held      <= jvs_pkg::KIND_OBJECT;
      byte_count     <= '0;
    end else if (step) begin
      phase          <= phase_next;
      nest_depth     <= nest_depth_next;
      escape_pending <= escape_pending_next;
      kind_held      <= kind_held_next;
      byte_count     <= byte_count_next;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    nest_depth <= jvs_pkg::CNT_W'(jvs_pkg::MAX_DEPTH))
    else $error("nesting depth beyond stack size");

  a_cont_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CONT || phase == PH_CSTR) |-> nest_depth != '0)
    else $error("inside a container with empty stack");

  a_bad_first: assert property (@(posedge clk) disable iff (rst)
    (fire && res.status == jvs_pkg::ST_BAD_FIRST) |->
      (res.length == '0 && res.value_kind == jvs_pkg::KIND_OBJECT && item.start_req))
    else $error("bad first byte result malformed");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE && !item.start_req) |-> !fire)
    else $error("result from a stray byte");

  a_stack_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("push and pop together");
`endif

endmodule

// File: dv/json_value_extent_scanner_tb.sv
// ----------------------------------------------------------------------------
// json_value_extent_scanner_tb
// self-checking bench for the json value extent scanner: a scoreboard class
// tracks the scan state byte by byte, predicts status, kind and length of each
// scan and compares them with the result beats; the text is mostly generated
// json (nested containers, escaped strings, tokens, deep bracket runs) mixed
// with damaged, cut-short and random text, under several depth limits and
// idle patterns on both channels
// ----------------------------------------------------------------------------
module json_value_extent_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1850;
  localparam int SEGMENTS     = 9;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 8;

  // characters the scanner reacts to, plus those the text generator uses
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_RBRACK = "]";
  localparam logic [7:0] CH_QUOTE  = "\"";
  localparam logic [7:0] CH_BSLASH = "\\";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_COLON  = ":";
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_EXP    = "e";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_T      = "t";
  localparam logic [7:0] CH_F      = "f";
  localparam logic [7:0] CH_N      = "n";
  localparam logic [7:0] CH_FILL   = "a";

  typedef enum logic [2:0] {SCAN_IDLE, SCAN_CONT, SCAN_CSTR, SCAN_STR, SCAN_TOK} scan_phase_t;

  // --------------------------------------------------------------------------
  // scoreboard: scan state tracker plus the queue of predicted extents
  // --------------------------------------------------------------------------
  class extent_scoreboard;
    scan_phase_t                      phase = SCAN_IDLE;
    int unsigned                      nest = 0;
    bit                               closer_is_brack [jvs_pkg::MAX_DEPTH];
    bit                               esc = 0;
    logic [2:0]                       kind_held = jvs_pkg::KIND_OBJECT;
    logic [jvs_pkg::LENGTH_WIDTH-1:0] consumed = '0;
    int unsigned                      depth_limit = jvs_pkg::DEPTH_LIMIT_RESET;
    jvs_pkg::jvs_out_t                predicted_extents [$];
    int                               errors = 0;
    int                               checked = 0;
    int                               status_seen [8];

    function int unsigned depth_cap();
      return (depth_limit < jvs_pkg::MAX_DEPTH) ? depth_limit : jvs_pkg::MAX_DEPTH;
    endfunction

    function int unsigned pending();
      return predicted_extents.size();
    endfunction

    function bit scanning();
      return phase != SCAN_IDLE;
    endfunction

    function void bump();
      if (consumed != '1) consumed++;
    endfunction

    function void emit(logic [2:0] st, logic [2:0] kd,
                       logic [jvs_pkg::LENGTH_WIDTH-1:0] len);
      jvs_pkg::jvs_out_t e;
      e.status     = st;
      e.value_kind = kd;
      e.length     = len;
      predicted_extents.push_back(e);
      phase = SCAN_IDLE;
    endfunction

    // advances the scan by one accepted byte; returns 0 for a byte ignored
    // between scans
    function bit take_byte(jvs_pkg::jvs_in_t b);
      logic [7:0] c;
      logic [2:0] kd;
      bit         bad;
      bit         ends;
      bit         want;
      c = b.text_byte;
      if (b.start_req) begin
        consumed = '0;
        nest     = 0;
        esc      = 0;
        bad      = 0;
        kd       = jvs_pkg::KIND_OBJECT;
        if (c == CH_LBRACE) kd = jvs_pkg::KIND_OBJECT;
        else if (c == CH_LBRACK) kd = jvs_pkg::KIND_ARRAY;
        else if (c == CH_QUOTE) kd = jvs_pkg::KIND_STRING;
        else if (c == CH_T || c == CH_F) kd = jvs_pkg::KIND_BOOL;
        else if (c == CH_N) kd = jvs_pkg::KIND_NULL;
        else if (c == CH_MINUS || (c >= CH_ZERO && c <= CH_NINE)) kd = jvs_pkg::KIND_NUMBER;
        else bad = 1;
        kind_held = kd;
        if (bad) begin
          emit(jvs_pkg::ST_BAD_FIRST, jvs_pkg::KIND_OBJECT, '0);
          return 1;
        end
        if (kd == jvs_pkg::KIND_OBJECT || kd == jvs_pkg::KIND_ARRAY) begin
          if (depth_cap() == 0) begin
            emit(jvs_pkg::ST_TOO_DEEP, kd, '0);
            return 1;
          end
          closer_is_brack[0] = (kd == jvs_pkg::KIND_ARRAY);
          nest  = 1;
          phase = SCAN_CONT;
        end else begin
          phase = (kd == jvs_pkg::KIND_STRING) ? SCAN_STR : SCAN_TOK;
        end
        bump();
      end else begin
        case (phase)
          SCAN_TOK: begin
            if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK || c == CH_SPACE ||
                c == CH_TAB || c == CH_LF || c == CH_CR) begin
              emit(jvs_pkg::ST_OK, kind_held, consumed);
              return 1;
            end
            bump();
          end
          SCAN_STR, SCAN_CSTR: begin
            bump();
            if (c == CH_BSLASH) begin
              esc = !esc;
            end else begin
              ends = (c == CH_QUOTE) && !esc;
              esc  = 0;
              if (ends) begin
                if (phase == SCAN_STR) begin
                  emit(jvs_pkg::ST_OK, kind_held, consumed);
                  return 1;
                end
                phase = SCAN_CONT;
              end
            end
          end
          SCAN_CONT: begin
            if (c == CH_QUOTE) begin
              esc   = 0;
              phase = SCAN_CSTR;
              bump();
            end else if (c == CH_LBRACE || c == CH_LBRACK) begin
              if (nest >= depth_cap()) begin
                emit(jvs_pkg::ST_TOO_DEEP, kind_held, consumed);
                return 1;
              end
              closer_is_brack[nest] = (c == CH_LBRACK);
              nest++;
              bump();
            end else if (c == CH_RBRACE || c == CH_RBRACK) begin
              want = (c == CH_RBRACK);
              if (nest == 0 || closer_is_brack[nest-1] != want) begin
                emit(jvs_pkg::ST_MISMATCH, kind_held, consumed);
                return 1;
              end
              nest--;
              bump();
              if (nest == 0) begin
                emit(jvs_pkg::ST_OK, kind_held, consumed);
                return 1;
              end
            end else begin
              bump();
            end
          end
          default: return 0;
        endcase
      end
      // end of buffer: a token is complete, anything else ran out
      if (b.last) begin
        emit((phase == SCAN_TOK) ? jvs_pkg::ST_OK : jvs_pkg::ST_RAN_OUT, kind_held, consumed);
      end
      return 1;
    endfunction

    function void check_extent(jvs_pkg::jvs_out_t got);
      jvs_pkg::jvs_out_t exp_e;
      if (predicted_extents.size() == 0) begin
        $error("result with nothing predicted: status %0d kind %0d length %0d",
               got.status, got.value_kind, got.length);
        errors++;
        return;
      end
      exp_e = predicted_extents.pop_front();
      checked++;
      status_seen[got.status]++;
      if (got.status !== exp_e.status) begin
        $error("status: expected %0d, got %0d", exp_e.status, got.status);
        errors++;
      end
      if (got.value_kind !== exp_e.value_kind) begin
        $error("value_kind: expected %0d, got %0d", exp_e.value_kind, got.value_kind);
        errors++;
      end
      if (got.length !== exp_e.length) begin
        $error("length: expected %0d, got %0d", exp_e.length, got.length);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block hookup
  // --------------------------------------------------------------------------
  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [jvs_pkg::DEPTH_LIMIT_W-1:0] cfg_data = '0;
  logic                              byte_valid = 1'b0;
  logic                              byte_stall;
  jvs_pkg::jvs_in_t                  byte_item = '0;
  logic                              result_valid;
  logic                              result_stall = 1'b0;
  jvs_pkg::jvs_out_t                 result;

  json_value_extent_scanner u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  extent_scoreboard sb = new();

  int         idle_pct  = 30;  // sender gap chance per cycle
  int         stall_pct = 84;  // receiver stall chance per cycle
  int         scan_bytes = 0;  // bytes that fed a scan, ignored bytes excluded
  int         cycles = 0;
  logic [7:0] doc [$];         // text of the scan being built

  // token enders and structural bytes for generated text
  logic [7:0] delim_set [7]   = '{CH_COMMA, CH_RBRACE, CH_RBRACK, CH_SPACE,
                                  CH_TAB, CH_LF, CH_CR};
  logic [7:0] bracket_set [6] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                                  CH_COMMA, CH_COLON};

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random, decided at each edge
  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // every accepted result beat goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_extent(result);
  end

  // watchdog
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("json_value_extent_scanner_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // text generation, appends to doc
  // --------------------------------------------------------------------------
  function automatic void push_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) doc.push_back(s[i]);
  endfunction

  // strings carry escape pairs, double backslashes and bracket bytes that
  // must not count as structure
  function automatic void gen_string();
    int         n, i, r;
    logic [7:0] c;
    doc.push_back(CH_QUOTE);
    n = $urandom_range(0, 6);
    for (i = 0; i < n; i++) begin
      r = $urandom_range(9);
      if (r < 2) begin
        doc.push_back(CH_BSLASH);
        doc.push_back($urandom_range(1) ? CH_QUOTE : 8'($urandom_range(255)));
      end else if (r == 2) begin
        doc.push_back(CH_BSLASH);
        doc.push_back(CH_BSLASH);
      end else if (r == 3) begin
        doc.push_back(bracket_set[$urandom_range(5)]);
      end else begin
        c = 8'($urandom_range(255));
        if (c == CH_QUOTE || c == CH_BSLASH) c = CH_FILL;
        doc.push_back(c);
      end
    end
    doc.push_back(CH_QUOTE);
  endfunction

  function automatic void gen_number();
    int i, n;
    if ($urandom_range(1)) doc.push_back(CH_MINUS);
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) doc.push_back(CH_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(2) == 0) begin
      doc.push_back(CH_DOT);
      doc.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
    if ($urandom_range(3) == 0) begin
      doc.push_back(CH_EXP);
      doc.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
      doc.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
  endfunction

  // well-formed value; containers only below max_lvl
  function automatic void gen_value(input int lvl, input int max_lvl);
    logic [2:0] kd;
    int         n, i;
    kd = (lvl < max_lvl)
         ? 3'($urandom_range(jvs_pkg::KIND_OBJECT, jvs_pkg::KIND_NUMBER))
         : 3'($urandom_range(jvs_pkg::KIND_STRING, jvs_pkg::KIND_NUMBER));
    case (kd)
      jvs_pkg::KIND_OBJECT: begin
        doc.push_back(CH_LBRACE);
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) begin
          if (i > 0) doc.push_back(CH_COMMA);
          if ($urandom_range(3) == 0) doc.push_back(CH_SPACE);
          gen_string();
          doc.push_back(CH_COLON);
          gen_value(lvl + 1, max_lvl);
        end
        doc.push_back(CH_RBRACE);
      end
      jvs_pkg::KIND_ARRAY: begin
        doc.push_back(CH_LBRACK);
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) begin
          if (i > 0) doc.push_back(CH_COMMA);
          if ($urandom_range(3) == 0) doc.push_back(CH_LF);
          gen_value(lvl + 1, max_lvl);
        end
        doc.push_back(CH_RBRACK);
      end
      jvs_pkg::KIND_STRING: gen_string();
      jvs_pkg::KIND_BOOL:   push_str($urandom_range(1) ? "true" : "false");
      jvs_pkg::KIND_NULL:   push_str("null");
      default:              gen_number();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // one input beat, with a random gap in front; valid stays high between
  // back-to-back beats
  task automatic send_item(input jvs_pkg::jvs_in_t it);
    if ($urandom_range(99) < idle_pct) begin
      byte_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    if (sb.take_byte(it)) scan_bytes++;
  endtask

  // doc as one scan: start on the first byte, optional last on the final one
  task automatic send_doc(input bit with_last);
    jvs_pkg::jvs_in_t it;
    int               i;
    for (i = 0; i < doc.size(); i++) begin
      it.text_byte = doc[i];
      it.start_req = (i == 0);
      it.last      = with_last && (i == doc.size() - 1);
      send_item(it);
    end
    doc.delete();
  endtask

  // sender holds off until every predicted result has come back
  task automatic hold_until_results();
    byte_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // leaves the block idle: a scan still open is closed by a last beat,
  // then results drain and the pipeline settles
  task automatic drain_block();
    jvs_pkg::jvs_in_t it;
    if (sb.scanning()) begin
      it.text_byte = 8'($urandom_range(255));
      it.start_req = 1'b0;
      it.last      = 1'b1;
      send_item(it);
    end
    hold_until_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_depth_limit(input logic [jvs_pkg::DEPTH_LIMIT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.depth_limit = v;
  endtask

  // one random scan: mostly well-formed json, plus deep bracket runs,
  // damaged text, text cut short and plain noise
  task automatic send_random_scan();
    int               pick, n, i, k, cap, flip_at;
    bit               opened [66];
    jvs_pkg::jvs_in_t it;
    pick = $urandom_range(99);
    if (pick < 55) begin
      gen_value(0, $urandom_range(0, 4));
      // a top-level token needs its ender
      if (doc[0] != CH_LBRACE && doc[0] != CH_LBRACK && doc[0] != CH_QUOTE)
        doc.push_back(delim_set[$urandom_range(6)]);
      send_doc($urandom_range(6) == 0);
      n = $urandom_range(0, 2);
      for (i = 0; i < n; i++) begin
        it.text_byte = 8'($urandom_range(255));
        it.start_req = 1'b0;
        it.last      = ($urandom_range(3) == 0);
        send_item(it);
      end
    end else if (pick < 67) begin
      // bracket run around the depth limit or of random length, sometimes a wrong closer
      cap = sb.depth_cap();
      if ($urandom_range(1)) k = cap - 1 + $urandom_range(0, 2);
      else k = $urandom_range(1, 66);
      if (k < 1) k = 1;
      if (k > 66) k = 66;
      for (i = 0; i < k; i++) begin
        opened[i] = $urandom_range(1);
        doc.push_back(opened[i] ? CH_LBRACK : CH_LBRACE);
        if ($urandom_range(7) == 0) gen_string();
      end
      flip_at = ($urandom_range(3) == 0) ? $urandom_range(0, k - 1) : -1;
      for (i = k - 1; i >= 0; i--)
        doc.push_back((opened[i] ^ (i == flip_at)) ? CH_RBRACK : CH_RBRACE);
      send_doc($urandom_range(7) == 0);
    end else if (pick < 77) begin
      gen_value(0, $urandom_range(1, 3));
      doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(255));
      send_doc($urandom_range(3) == 0);
    end else if (pick < 89) begin
      // cut short: runs out on last, or is abandoned by the next start
      gen_value(0, $urandom_range(1, 4));
      if (doc.size() > 1) begin
        k = $urandom_range(1, doc.size() - 1);
        while (doc.size() > k) void'(doc.pop_back());
      end
      send_doc($urandom_range(1));
    end else begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        it.text_byte = 8'($urandom_range(255));
        it.start_req = (i == 0) || ($urandom_range(3) == 0);
        it.last      = ($urandom_range(7) == 0);
        send_item(it);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  int unsigned limit_plan [SEGMENTS] = '{1, 64, 0, 2, 127, 5, 65, 3, 63};

  initial begin
    int seg, base;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: one of each kind, bad first, mismatch and ran-out statuses, escapes, abandon
    send_item('{text_byte: 8'hFF, start_req: 1'b1, last: 1'b0});  // bad first byte
    push_str("[]");          send_doc(0);
    push_str("\"\\\"\"");    send_doc(0);   // escaped quote, then the closing one
    push_str("t,");          send_doc(0);
    push_str("n]");          send_doc(0);
    push_str("-,");          send_doc(0);
    push_str("{]");          send_doc(0);   // wrong closer
    push_str("\"ab");        send_doc(1);   // string runs out
    push_str("5");           send_doc(1);   // token ended by last on its start byte
    send_item('{text_byte: CH_FILL, start_req: 1'b0, last: 1'b0});  // idle byte
    push_str("[");           send_doc(0);   // abandoned by the next start
    push_str("f");           send_doc(1);
    push_str("[\"]\"]");     send_doc(0);   // closer inside a string is text

    // random segments, each with its own depth limit; three idle patterns, each for three segments
    base = scan_bytes;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0:       begin idle_pct = 30; stall_pct = 84; end
        1:       begin idle_pct = 84; stall_pct = 30; end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      drain_block();
      write_depth_limit(jvs_pkg::DEPTH_LIMIT_W'(limit_plan[seg]));
      while (scan_bytes < base + RANDOM_ITEMS * (seg + 1) / SEGMENTS) begin
        send_random_scan();
        if ($urandom_range(39) == 0) hold_until_results();
      end
    end

    drain_block();
    $display("covered %0d scan bytes, %0d depth limits, three idle patterns",
             scan_bytes, SEGMENTS);
    $display("results %0d: ok %0d, bad first %0d, mismatch %0d, too deep %0d, ran out %0d",
             sb.checked, sb.status_seen[jvs_pkg::ST_OK],
             sb.status_seen[jvs_pkg::ST_BAD_FIRST],
             sb.status_seen[jvs_pkg::ST_MISMATCH],
             sb.status_seen[jvs_pkg::ST_TOO_DEEP],
             sb.status_seen[jvs_pkg::ST_RAN_OUT]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("json_value_extent_scanner_tb: PASS");
    end else begin
      $display("json_value_extent_scanner_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/jvs_pkg.sv
rtl/jvs_closer_stack.sv
rtl/jvs_scan_ctl.sv
rtl/json_value_extent_scanner.sv
dv/json_value_extent_scanner_tb.sv
